FILE: sv/eabv_pkg.sv
// eabv_pkg: shared types, constants and fixed-point helpers for the
// Euler-angle to basis-vector pipeline. No dependencies.
`default_nettype none

package eabv_pkg;

    // Sign/magnitude Q2.30 value; neg is set only for nonzero magnitudes.
    typedef struct packed {
        logic        neg;
        logic [31:0] mag;
    } sm_t;

    localparam int LATENCY = 12;

    localparam logic [31:0] HALF_Q30 = 32'h2000_0000;
    localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
    localparam logic [31:0] QUARTER  = 32'h4000_0000;

    // Taylor coefficients of sin(pi/2*t), Q2.30 magnitudes
    localparam logic [31:0] K11 = 32'd3864;
    // [0]=K9 [1]=K7 [2]=K5 [3]=K3 [4]=K1
    localparam logic [4:0][31:0] KCOEF = {
        32'd1686629713, 32'd693598668, 32'd85569306, 32'd5026995, 32'd172272
    };

    // unsigned Q30 product, rounded half up
    function automatic logic [31:0] mulq(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] pr;
        logic [64:0] s;
        pr = 64'(a) * 64'(b);
        s  = {1'b0, pr} + 65'(HALF_Q30);
        return s[61:30];
    endfunction

    // signed Q30 product, rounded half away from zero
    function automatic sm_t qmul(input sm_t a, input sm_t b);
        sm_t r;
        r.mag = mulq(a.mag, b.mag);
        r.neg = (a.neg ^ b.neg) && (r.mag != 32'd0);
        return r;
    endfunction

    function automatic logic signed [34:0] to_s(input sm_t a);
        logic signed [34:0] m;
        m = $signed({3'b000, a.mag});
        return a.neg ? -m : m;
    endfunction

endpackage

`default_nettype wire

FILE: sv/eabv_sin.sv
// eabv_sin: eight-stage pipelined sine of a 32-bit phase, Q2.30 result in
// sign/magnitude form (Horner Taylor polynomial). Depends on eabv_pkg.
`default_nettype none

module eabv_sin (
    input  wire logic         clk,
    input  wire logic [31:0]  phase,
    output eabv_pkg::sm_t     res
);
    import eabv_pkg::*;

    logic [31:0] t_reg  [0:6];
    logic [1:0]  q_reg  [0:6];
    logic [31:0] t2_reg [0:4];
    logic [31:0] p_reg  [0:4];
    sm_t         res_reg;

    logic [31:0] t_next;
    logic [31:0] p_next [0:4];
    sm_t         res_next;

    always_comb
    begin
        t_next = phase[30] ? (ONE_Q30 - {2'b00, phase[29:0]}) : {2'b00, phase[29:0]};
        for (int h = 0; h < 5; h++)
        begin
            p_next[h] = KCOEF[h] - mulq((h == 0) ? K11 : p_reg[(h == 0) ? 0 : h - 1],
                                        t2_reg[h]);
        end
        res_next.mag = mulq(p_reg[4], t_reg[6]);
        res_next.neg = q_reg[6][1] && (res_next.mag != 32'd0);
    end

    always_ff @(posedge clk)
    begin
        t_reg[0]  <= t_next;
        q_reg[0]  <= phase[31:30];
        t2_reg[0] <= mulq(t_reg[0], t_reg[0]);
        for (int s = 1; s < 7; s++)
        begin
            t_reg[s] <= t_reg[s-1];
            q_reg[s] <= q_reg[s-1];
        end
        for (int h = 1; h < 5; h++)
        begin
            t2_reg[h] <= t2_reg[h-1];
        end
        for (int h = 0; h < 5; h++)
        begin
            p_reg[h] <= p_next[h];
        end
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

FILE: sv/euler_angles_to_basis_vectors.sv
// euler_angles_to_basis_vectors: top level, pitch/yaw/roll to three
// Q1.14 basis vectors. Depends on eabv_pkg and eabv_sin.
//
// Usage:
//   A request (pitch, yaw, roll, mode) is taken at each rising edge where
//   start is high and busy is low. busy is always low: the pipeline takes
//   one request every cycle.
//   The pipeline is 8 stages of sine/cosine lanes (one multiplier per
//   Horner step in each lane), two product stages, one sum stage and
//   the output rounding register. done is high for exactly one cycle with
//   the nine vector components; the results are valid only in that cycle.
//   Throughput: one result per cycle, set by the fully pipelined lanes.
//   Mode 0 gives forward, side and up rows; mode 1 columns with y negated.
//   Reset clears the valid pipeline only; no request in flight survives it.
//   The receiver cannot stall; nothing is held back.
`default_nettype none

module euler_angles_to_basis_vectors #(
    parameter int ANGLE_BITS    = 16,
    parameter int OUT_FRAC_BITS = 14
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] pitch,
    input  wire logic signed [15:0] yaw,
    input  wire logic signed [15:0] roll,
    input  wire logic               mode,
    output logic                    done,
    output logic signed [15:0]      fwd_x,
    output logic signed [15:0]      fwd_y,
    output logic signed [15:0]      fwd_z,
    output logic signed [15:0]      side_x,
    output logic signed [15:0]      side_y,
    output logic signed [15:0]      side_z,
    output logic signed [15:0]      up_x,
    output logic signed [15:0]      up_y,
    output logic signed [15:0]      up_z
);
    import eabv_pkg::*;

    localparam int SH = 30 - OUT_FRAC_BITS;
    localparam logic [32:0] RND = (33'd1 << SH) >> 1;
    localparam logic signed [34:0] LIM = 35'sh0_4000_0000;

    function automatic logic [15:0] to_out(input logic signed [34:0] v);
        logic signed [34:0] c;
        logic               n;
        logic [30:0]        m;
        logic [31:0]        r;
        c = v;
        if (c > LIM)
            c = LIM;
        if (c < -LIM)
            c = -LIM;
        n = c < 0;
        m = n ? 31'(-c) : 31'(c);
        r = 32'((33'(m) + RND) >> SH);
        return n ? 16'(-r) : r[15:0];
    endfunction

    logic [LATENCY-1:0] vld_reg, vld_next;
    logic [9:0]         mode_reg;
    logic               accept;

    logic [31:0] ph_p, ph_y, ph_r;
    sm_t sp, cp, sy, cy, sr, cr;

    sm_t l1_reg [0:9];
    sm_t sp_l1_reg, sy_l1_reg, cy_l1_reg;
    sm_t l2_reg [0:11];
    sm_t sp_l2_reg;
    logic signed [34:0] v_reg [0:8];
    logic signed [34:0] v_next [0:8];
    logic [15:0] out_reg [0:8];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign ph_p = 32'({{16{pitch[15]}}, pitch} << (32 - ANGLE_BITS));
    assign ph_y = 32'({{16{yaw[15]}}, yaw} << (32 - ANGLE_BITS));
    assign ph_r = 32'({{16{roll[15]}}, roll} << (32 - ANGLE_BITS));

    eabv_sin u_sp (.clk(clk), .phase(ph_p),           .res(sp));
    eabv_sin u_cp (.clk(clk), .phase(ph_p + QUARTER), .res(cp));
    eabv_sin u_sy (.clk(clk), .phase(ph_y),           .res(sy));
    eabv_sin u_cy (.clk(clk), .phase(ph_y + QUARTER), .res(cy));
    eabv_sin u_sr (.clk(clk), .phase(ph_r),           .res(sr));
    eabv_sin u_cr (.clk(clk), .phase(ph_r + QUARTER), .res(cr));

    assign vld_next = {vld_reg[LATENCY-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= {mode_reg[8:0], mode};
    end

    // first product level
    always_ff @(posedge clk)
    begin
        l1_reg[0] <= qmul(cp, cy);
        l1_reg[1] <= qmul(cp, sy);
        l1_reg[2] <= qmul(cr, sy);
        l1_reg[3] <= qmul(cr, cy);
        l1_reg[4] <= qmul(sr, cp);
        l1_reg[5] <= qmul(sr, sy);
        l1_reg[6] <= qmul(sr, cy);
        l1_reg[7] <= qmul(cr, cp);
        l1_reg[8] <= qmul(sr, sp);
        l1_reg[9] <= qmul(cr, sp);
        sp_l1_reg <= sp;
        sy_l1_reg <= sy;
        cy_l1_reg <= cy;
    end

    // second product level
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 8; i++)
        begin
            l2_reg[i] <= l1_reg[i];
        end
        l2_reg[8]  <= qmul(l1_reg[8], cy_l1_reg);
        l2_reg[9]  <= qmul(l1_reg[8], sy_l1_reg);
        l2_reg[10] <= qmul(l1_reg[9], cy_l1_reg);
        l2_reg[11] <= qmul(l1_reg[9], sy_l1_reg);
        sp_l2_reg  <= sp_l1_reg;
    end

    always_comb
    begin
        logic signed [34:0] pcc, pcs, crsy, crcy, srcp, srsy, srcy, crcp, a, b, c, d, nsp;
        pcc  = to_s(l2_reg[0]);
        pcs  = to_s(l2_reg[1]);
        crsy = to_s(l2_reg[2]);
        crcy = to_s(l2_reg[3]);
        srcp = to_s(l2_reg[4]);
        srsy = to_s(l2_reg[5]);
        srcy = to_s(l2_reg[6]);
        crcp = to_s(l2_reg[7]);
        a    = to_s(l2_reg[8]);
        b    = to_s(l2_reg[9]);
        c    = to_s(l2_reg[10]);
        d    = to_s(l2_reg[11]);
        nsp  = -to_s(sp_l2_reg);
        v_next[0] = pcc;
        v_next[8] = crcp;
        if (!mode_reg[9])
        begin
            v_next[1] = pcs;
            v_next[2] = nsp;
            v_next[3] = crsy - a;
            v_next[4] = -b - crcy;
            v_next[5] = -srcp;
            v_next[6] = c + srsy;
            v_next[7] = d - srcy;
        end
        else
        begin
            v_next[1] = a - crsy;
            v_next[2] = c + srsy;
            v_next[3] = pcs;
            v_next[4] = b + crcy;
            v_next[5] = d - srcy;
            v_next[6] = nsp;
            v_next[7] = srcp;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 9; i++)
        begin
            v_reg[i]   <= v_next[i];
            out_reg[i] <= to_out(v_reg[i]);
        end
    end

    assign done   = vld_reg[LATENCY-1];
    assign fwd_x  = out_reg[0];
    assign fwd_y  = out_reg[1];
    assign fwd_z  = out_reg[2];
    assign side_x = out_reg[3];
    assign side_y = out_reg[4];
    assign side_z = out_reg[5];
    assign up_x   = out_reg[6];
    assign up_y   = out_reg[7];
    assign up_z   = out_reg[8];

`ifndef SYNTHESIS
    a_req_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##12 done)
        else $error("request did not complete after pipeline latency");
    a_done_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 12))
        else $error("result without matching request");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("pipeline refused a request");
`endif

endmodule

`default_nettype wire
